// ----- rtl/sydec_pkg.sv -----
// shared types, constants and character decoders of the syllable word decoder
// no dependencies; used by every module of the block
package sydec_pkg;

    localparam int CHAR_W  = 8;
    localparam int MAG_W   = 63;
    localparam int VALUE_W = 64;
    localparam int GRP_W   = 5;
    localparam int VOW_W   = 3;
    localparam int DIGIT_W = 7;

    localparam logic [CHAR_W-1:0] CH_END = 8'h00;
    localparam logic [CHAR_W-1:0] CH_A   = 8'h61;
    localparam logic [CHAR_W-1:0] CH_B   = 8'h62;
    localparam logic [CHAR_W-1:0] CH_C   = 8'h63;
    localparam logic [CHAR_W-1:0] CH_D   = 8'h64;
    localparam logic [CHAR_W-1:0] CH_E   = 8'h65;
    localparam logic [CHAR_W-1:0] CH_F   = 8'h66;
    localparam logic [CHAR_W-1:0] CH_G   = 8'h67;
    localparam logic [CHAR_W-1:0] CH_H   = 8'h68;
    localparam logic [CHAR_W-1:0] CH_I   = 8'h69;
    localparam logic [CHAR_W-1:0] CH_J   = 8'h6a;
    localparam logic [CHAR_W-1:0] CH_K   = 8'h6b;
    localparam logic [CHAR_W-1:0] CH_L   = 8'h6c;
    localparam logic [CHAR_W-1:0] CH_M   = 8'h6d;
    localparam logic [CHAR_W-1:0] CH_N   = 8'h6e;
    localparam logic [CHAR_W-1:0] CH_O   = 8'h6f;
    localparam logic [CHAR_W-1:0] CH_P   = 8'h70;
    localparam logic [CHAR_W-1:0] CH_R   = 8'h72;
    localparam logic [CHAR_W-1:0] CH_S   = 8'h73;
    localparam logic [CHAR_W-1:0] CH_T   = 8'h74;
    localparam logic [CHAR_W-1:0] CH_U   = 8'h75;
    localparam logic [CHAR_W-1:0] CH_W   = 8'h77;
    localparam logic [CHAR_W-1:0] CH_X   = 8'h78;
    localparam logic [CHAR_W-1:0] CH_Y   = 8'h79;
    localparam logic [CHAR_W-1:0] CH_Z   = 8'h7a;

    localparam logic [GRP_W-1:0] GRP_B  = 5'd0;
    localparam logic [GRP_W-1:0] GRP_CH = 5'd1;
    localparam logic [GRP_W-1:0] GRP_D  = 5'd2;
    localparam logic [GRP_W-1:0] GRP_F  = 5'd3;
    localparam logic [GRP_W-1:0] GRP_G  = 5'd4;
    localparam logic [GRP_W-1:0] GRP_H  = 5'd5;
    localparam logic [GRP_W-1:0] GRP_J  = 5'd6;
    localparam logic [GRP_W-1:0] GRP_K  = 5'd7;
    localparam logic [GRP_W-1:0] GRP_L  = 5'd8;
    localparam logic [GRP_W-1:0] GRP_M  = 5'd9;
    localparam logic [GRP_W-1:0] GRP_N  = 5'd10;
    localparam logic [GRP_W-1:0] GRP_P  = 5'd11;
    localparam logic [GRP_W-1:0] GRP_R  = 5'd12;
    localparam logic [GRP_W-1:0] GRP_S  = 5'd13;
    localparam logic [GRP_W-1:0] GRP_SH = 5'd14;
    localparam logic [GRP_W-1:0] GRP_T  = 5'd15;
    localparam logic [GRP_W-1:0] GRP_TS = 5'd16;
    localparam logic [GRP_W-1:0] GRP_W_ = 5'd17;
    localparam logic [GRP_W-1:0] GRP_Y  = 5'd18;
    localparam logic [GRP_W-1:0] GRP_Z  = 5'd19;

    typedef enum logic [2:0] {
        PH_START,
        PH_SIGN,
        PH_SYL,
        PH_VOWEL,
        PH_C,
        PH_S,
        PH_T
    } phase_t;

    typedef struct packed {
        logic             hit;
        logic [VOW_W-1:0] code;
    } vowel_t;

    typedef struct packed {
        logic             hit;
        logic [GRP_W-1:0] code;
    } group_t;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               is_error;
    } word_result_t;

    function automatic vowel_t vowel_code(input logic [CHAR_W-1:0] ch);
        vowel_t v;
        v.hit = 1'b1;
        unique case (ch)
            CH_A:    v.code = 3'd0;
            CH_I:    v.code = 3'd1;
            CH_U:    v.code = 3'd2;
            CH_E:    v.code = 3'd3;
            CH_O:    v.code = 3'd4;
            default:
            begin
                v.hit  = 1'b0;
                v.code = 3'd0;
            end
        endcase
        return v;
    endfunction

    // single-letter consonants that need no look-ahead
    function automatic group_t plain_group(input logic [CHAR_W-1:0] ch);
        group_t g;
        g.hit = 1'b1;
        unique case (ch)
            CH_B:    g.code = GRP_B;
            CH_D:    g.code = GRP_D;
            CH_F:    g.code = GRP_F;
            CH_G:    g.code = GRP_G;
            CH_H:    g.code = GRP_H;
            CH_J:    g.code = GRP_J;
            CH_K:    g.code = GRP_K;
            CH_L:    g.code = GRP_L;
            CH_M:    g.code = GRP_M;
            CH_N:    g.code = GRP_N;
            CH_P:    g.code = GRP_P;
            CH_R:    g.code = GRP_R;
            CH_W:    g.code = GRP_W_;
            CH_Y:    g.code = GRP_Y;
            CH_Z:    g.code = GRP_Z;
            default:
            begin
                g.hit  = 1'b0;
                g.code = GRP_B;
            end
        endcase
        return g;
    endfunction

endpackage

// ----- rtl/sydec_accum.sv -----
// base-100 multiply-add of the magnitude with one syllable digit, plus overflow
// depends on sydec_pkg
module sydec_accum
    import sydec_pkg::*;
(
    input  logic [MAG_W-1:0] magnitude,
    input  logic [GRP_W-1:0] grp,
    input  logic [VOW_W-1:0] vow,
    output logic [MAG_W-1:0] sum,
    output logic             overflow
);

    // 100 * (2^63 - 1) + 99 fits in 70 bits; one spare
    localparam int WIDE_W = MAG_W + 8;

    logic [DIGIT_W-1:0] digit;
    logic [WIDE_W-1:0]  mag_wide;
    logic [WIDE_W-1:0]  wide_sum;

    // digit = grp * 5 + vow
    assign digit = {grp, 2'b00} + DIGIT_W'(grp) + DIGIT_W'(vow);

    assign mag_wide = {8'd0, magnitude};

    // x * 100 = x * 64 + x * 32 + x * 4
    assign wide_sum = (mag_wide << 6) + (mag_wide << 5) + (mag_wide << 2)
                    + WIDE_W'(digit);

    assign sum      = wide_sum[MAG_W-1:0];
    assign overflow = |wide_sum[WIDE_W-1:MAG_W];

endmodule

// ----- rtl/sydec_parser.sv -----
// syllable parser: word state registers and next-state logic for one character
// depends on sydec_pkg and sydec_accum
module sydec_parser
    import sydec_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              take,
    input  logic [CHAR_W-1:0] ch,
    output word_result_t      result
);

    phase_t           phase_reg, phase_next;
    logic [MAG_W-1:0] magnitude_reg, magnitude_next;
    logic             negative_reg, negative_next;
    logic             failed_reg, failed_next;
    logic [GRP_W-1:0] group_reg, group_next;

    vowel_t           vw;
    group_t           pg;
    logic [MAG_W-1:0] acc_sum;
    logic             acc_ovf;
    logic             word_err;
    logic [VALUE_W-1:0] mag_ext;

    assign vw = vowel_code(ch);
    assign pg = plain_group(ch);

    sydec_accum u_accum (
        .magnitude (magnitude_reg),
        .grp       (group_reg),
        .vow       (vw.code),
        .sum       (acc_sum),
        .overflow  (acc_ovf)
    );

    assign word_err = failed_reg || !(phase_reg == PH_START || phase_reg == PH_SYL);
    assign mag_ext  = {1'b0, magnitude_reg};

    always_comb
    begin
        result.is_error = word_err;
        if (word_err)
        begin
            result.value = '0;
        end
        else if (negative_reg)
        begin
            result.value = -mag_ext;
        end
        else
        begin
            result.value = mag_ext;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_START;
            magnitude_reg <= '0;
            negative_reg  <= 1'b0;
            failed_reg    <= 1'b0;
            group_reg     <= '0;
        end
        else
        begin
            phase_reg     <= phase_next;
            magnitude_reg <= magnitude_next;
            negative_reg  <= negative_next;
            failed_reg    <= failed_next;
            group_reg     <= group_next;
        end
    end

    always_comb
    begin
        phase_next     = phase_reg;
        magnitude_next = magnitude_reg;
        negative_next  = negative_reg;
        failed_next    = failed_reg;
        group_next     = group_reg;

        if (take)
        begin
            if (ch == CH_END)
            begin
                phase_next     = PH_START;
                magnitude_next = '0;
                negative_next  = 1'b0;
                failed_next    = 1'b0;
                group_next     = '0;
            end
            else if (!failed_reg)
            begin
                unique case (phase_reg)
                    PH_START, PH_SYL:
                    begin
                        // sign prefix only counts at the very start
                        if (phase_reg == PH_START && ch == CH_X)
                        begin
                            phase_next = PH_SIGN;
                        end
                        else if (pg.hit)
                        begin
                            group_next = pg.code;
                            phase_next = PH_VOWEL;
                        end
                        else if (ch == CH_C)
                        begin
                            phase_next = PH_C;
                        end
                        else if (ch == CH_S)
                        begin
                            group_next = GRP_S;
                            phase_next = PH_S;
                        end
                        else if (ch == CH_T)
                        begin
                            group_next = GRP_T;
                            phase_next = PH_T;
                        end
                        else
                        begin
                            failed_next = 1'b1;
                        end
                    end
                    PH_SIGN:
                    begin
                        if (ch == CH_A)
                        begin
                            negative_next = 1'b1;
                            phase_next    = PH_SYL;
                        end
                        else
                        begin
                            failed_next = 1'b1;
                        end
                    end
                    PH_C:
                    begin
                        if (ch == CH_H)
                        begin
                            group_next = GRP_CH;
                            phase_next = PH_VOWEL;
                        end
                        else
                        begin
                            failed_next = 1'b1;
                        end
                    end
                    PH_VOWEL, PH_S, PH_T:
                    begin
                        if (phase_reg == PH_S && ch == CH_H)
                        begin
                            group_next = GRP_SH;
                            phase_next = PH_VOWEL;
                        end
                        else if (phase_reg == PH_T && ch == CH_S)
                        begin
                            group_next = GRP_TS;
                            phase_next = PH_VOWEL;
                        end
                        else if (vw.hit && !acc_ovf)
                        begin
                            magnitude_next = acc_sum;
                            phase_next     = PH_SYL;
                        end
                        else
                        begin
                            // bad vowel or magnitude past 2^63-1
                            failed_next = 1'b1;
                        end
                    end
                    default:
                    begin
                        failed_next = 1'b1;
                    end
                endcase
            end
        end
    end

endmodule

// ----- rtl/syllable_word_to_integer_decoder_unit.sv -----
// top level of the syllable word decoder: input beat register, parser, result register
// depends on sydec_pkg and sydec_parser
//
//  channel  | direction | payload
//  ---------+-----------+--------------------------------------------------
//  s_axis   | in        | tdata[7:0] character (0 ends the word)
//  m_axis   | out       | tdata[63:0] value (signed), tuser[0] is_error
//
// one character per cycle, unless an end character waits on a full result register;
// the parser updates word state from the input register, so beats arrive back to back.
// the result register loads a result beat when the parser takes its ending character.
// only an end character waits on a full result register; letters keep flowing.
// rst_n clears the word state and both valid flags.
module syllable_word_to_integer_decoder_unit
    import sydec_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [CHAR_W-1:0]  s_axis_tdata,   // [7:0] character
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [VALUE_W-1:0] m_axis_tdata,   // [63:0] value
    output logic               m_axis_tuser    // [0] is_error
);

    logic              in_valid_reg;
    logic [CHAR_W-1:0] ch_reg;
    logic              out_valid_reg;
    logic [VALUE_W-1:0] value_reg;
    logic              err_reg;

    logic              out_free;
    logic              take;
    logic              emit;
    word_result_t      result;

    assign out_free = !out_valid_reg || m_axis_tready;
    assign take     = in_valid_reg && (ch_reg != CH_END || out_free);
    assign emit     = take && ch_reg == CH_END;

    assign s_axis_tready = !in_valid_reg || take;

    sydec_parser u_parser (
        .clk    (clk),
        .rst_n  (rst_n),
        .take   (take),
        .ch     (ch_reg),
        .result (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (out_free)
            begin
                out_valid_reg <= emit;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            ch_reg <= s_axis_tdata;
        end
        if (emit)
        begin
            value_reg <= result.value;
            err_reg   <= result.is_error;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = value_reg;
    assign m_axis_tuser  = err_reg;

endmodule
